FILE: rtl/fpr_pkg.sv
// ----------------------------------------------------------------------------
// fpr_pkg
// Shared types and constants of the fifo page replacement unit.
// ----------------------------------------------------------------------------
package fpr_pkg;

  localparam int PAGE_IN_W = 16;  // page_number port width
  localparam int SLOT_W    = 4;   // slot port width
  localparam int NF_W      = 5;   // num_frames register width
  localparam int TOTAL_W   = 32;  // running totals width
  localparam int CFG_AW    = 2;   // apb byte address width
  localparam int CFG_DW    = 32;  // apb data width

  localparam logic [NF_W-1:0]   NUM_FRAMES_RESET = 5'd4;
  localparam logic [CFG_AW-1:0] REG_NUM_FRAMES   = 2'd0;

  // controller to datapath
  typedef struct packed {
    logic load;          // take a new request
    logic scan;          // walk the frames
    logic commit_hit;    // finish request as a hit
    logic commit_fault;  // finish request as a fault, fill victim frame
  } ctl_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic match;         // compared frame holds the page
    logic miss_last;     // last frame compared without a match
  } dp_stat_t;

endpackage

FILE: rtl/fpr_ram.sv
// ----------------------------------------------------------------------------
// fpr_ram
// Generic single write port, single read port RAM with registered read data.
// ----------------------------------------------------------------------------
module fpr_ram #(
  parameter int WIDTH = 16,
  parameter int DEPTH = 16
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                       wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/fpr_ctrl.sv
// ----------------------------------------------------------------------------
// fpr_ctrl
// Request sequencer: idle, then frame scan until a hit or the last miss.
// ----------------------------------------------------------------------------
module fpr_ctrl (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  fpr_pkg::dp_stat_t stat,
  output fpr_pkg::ctl_cmd_t cmd
);

  import fpr_pkg::*;

  localparam logic S_IDLE = 1'b0;
  localparam logic S_SCAN = 1'b1;

  logic state;
  logic state_next;

  always_comb begin
    cmd              = '0;
    state_next       = state;
    unique case (state)
      S_IDLE: begin
        if (start) begin
          cmd.load   = 1'b1;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        cmd.scan         = 1'b1;
        cmd.commit_hit   = stat.match;
        cmd.commit_fault = stat.miss_last;
        if (stat.match || stat.miss_last) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  assign busy = (state != S_IDLE);

  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> busy)
    else $error("accepted request did not start a scan");

  a_commit_idle: assert property (@(posedge clk) disable iff (rst)
    (cmd.commit_hit || cmd.commit_fault) |=> !busy)
    else $error("controller stayed busy after commit");

  a_commit_excl: assert property (@(posedge clk) disable iff (rst)
    !(cmd.commit_hit && cmd.commit_fault))
    else $error("hit and fault committed together");

endmodule

FILE: rtl/fpr_dp.sv
// ----------------------------------------------------------------------------
// fpr_dp
// Datapath: frame store, valid bits, pipelined compare, fill pointer, totals.
// ----------------------------------------------------------------------------
module fpr_dp #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                              clk,
  input  logic                              rst,
  input  fpr_pkg::ctl_cmd_t                 cmd,
  output fpr_pkg::dp_stat_t                 stat,
  input  logic [fpr_pkg::PAGE_IN_W-1:0]     page_number,
  input  logic [fpr_pkg::NF_W-1:0]          num_frames,
  output logic                              done,
  output logic                              hit,
  output logic [fpr_pkg::SLOT_W-1:0]        slot,
  output logic [fpr_pkg::TOTAL_W-1:0]       fault_total,
  output logic [fpr_pkg::TOTAL_W-1:0]       hit_total
);

  import fpr_pkg::*;

  localparam int IDX_W = (MAX_FRAMES > 1) ? $clog2(MAX_FRAMES) : 1;
  localparam int CNT_W = $clog2(MAX_FRAMES + 1);
  localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_FRAMES);
  localparam logic [CNT_W-1:0] ONE_CNT = CNT_W'(1);

  logic [PAGE_BITS-1:0]  page_key;
  logic [PAGE_BITS-1:0]  page_reg;
  logic [CNT_W-1:0]      count_in;
  logic [CNT_W-1:0]      count_reg;
  logic [CNT_W-1:0]      scan_idx;
  logic                  issue;
  logic                  cmp_live;
  logic                  cmp_last;
  logic [IDX_W-1:0]      cmp_idx;
  logic [PAGE_BITS-1:0]  rdata;
  logic [MAX_FRAMES-1:0] frame_valid;
  logic [IDX_W-1:0]      fill_ptr;
  logic [IDX_W-1:0]      victim;
  logic [CNT_W-1:0]      victim_inc;
  logic [IDX_W-1:0]      fill_next;
  logic [TOTAL_W-1:0]    fault_cnt;
  logic [TOTAL_W-1:0]    hit_cnt;

  // keep the low PAGE_BITS of the request
  assign page_key = PAGE_BITS'({{(32 - PAGE_IN_W){1'b0}}, page_number});

  // frames in use: zero reads as one, clamp at the built count
  always_comb begin
    priority if (num_frames == '0) begin
      count_in = ONE_CNT;
    end else if (32'(num_frames) > MAX_FRAMES) begin
      count_in = MAX_CNT;
    end else begin
      count_in = CNT_W'(num_frames);
    end
  end

  assign issue = cmd.scan && (scan_idx < count_reg);

  fpr_ram #(
    .WIDTH (PAGE_BITS),
    .DEPTH (MAX_FRAMES)
  ) u_frames (
    .clk   (clk),
    .we    (cmd.commit_fault),
    .waddr (victim),
    .wdata (page_reg),
    .raddr (scan_idx[IDX_W-1:0]),
    .rdata (rdata)
  );

  assign stat.match     = cmp_live && frame_valid[cmp_idx] && (rdata == page_reg);
  assign stat.miss_last = cmp_live && cmp_last && !stat.match;

  // fifo victim, pointer past the count falls back to frame zero
  always_comb begin
    victim     = (CNT_W'(fill_ptr) >= count_reg) ? '0 : fill_ptr;
    victim_inc = CNT_W'(victim) + ONE_CNT;
    fill_next  = (victim_inc >= count_reg) ? '0 : victim_inc[IDX_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      page_reg  <= page_key;
      count_reg <= count_in;
    end
    if (issue) begin
      cmp_idx  <= scan_idx[IDX_W-1:0];
      cmp_last <= (scan_idx == (count_reg - ONE_CNT));
    end
    if (cmd.commit_hit || cmd.commit_fault) begin
      hit  <= cmd.commit_hit;
      slot <= cmd.commit_hit ? SLOT_W'(cmp_idx) : SLOT_W'(victim);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      scan_idx    <= '0;
      cmp_live    <= 1'b0;
      frame_valid <= '0;
      fill_ptr    <= '0;
      fault_cnt   <= '0;
      hit_cnt     <= '0;
      done        <= 1'b0;
    end else begin
      done <= cmd.commit_hit || cmd.commit_fault;
      if (cmd.load) begin
        scan_idx <= '0;
        cmp_live <= 1'b0;
      end else begin
        cmp_live <= issue;
        if (issue) begin
          scan_idx <= scan_idx + ONE_CNT;
        end
      end
      if (cmd.commit_hit) begin
        hit_cnt <= hit_cnt + TOTAL_W'(1);
      end
      if (cmd.commit_fault) begin
        fault_cnt           <= fault_cnt + TOTAL_W'(1);
        frame_valid[victim] <= 1'b1;
        fill_ptr            <= fill_next;
      end
    end
  end

  assign fault_total = fault_cnt;
  assign hit_total   = hit_cnt;

  a_done_single: assert property (@(posedge clk) disable iff (rst)
    done |=> !done)
    else $error("result strobe held for more than one cycle");

  a_cmp_in_range: assert property (@(posedge clk) disable iff (rst)
    cmp_live |-> (CNT_W'(cmp_idx) < count_reg))
    else $error("compare beyond frames in use");

  a_fault_fills: assert property (@(posedge clk) disable iff (rst)
    cmd.commit_fault |=> frame_valid[$past(victim)])
    else $error("faulted frame not marked valid");

endmodule

FILE: rtl/fifo_page_replacement_unit.sv
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit
// FIFO page replacement: looks up a page among the resident frames, fills the
// oldest frame on a fault, and keeps running fault and hit totals.
//
//   channel   signals                                   direction
//   request   start, busy, page_number                  in (busy out)
//   result    done, hit, slot, fault_total, hit_total   out, one cycle
//   config    psel penable pwrite paddr pwdata prdata   apb slave
//
// A fault ends the scan at the last of the N frames in use (1..MAX_FRAMES),
// and a hit ends it at the matching frame k: the scan reads one frame a cycle
// from the frame RAM and compares it in the cycle after the read.
// busy drops with the strobe, so the next request may be accepted while a
// result is shown.
// Reset is synchronous; valid bits clear at once, no clearing pass.
// The result receiver cannot stall; each result is shown for one cycle.
// ----------------------------------------------------------------------------
module fifo_page_replacement_unit #(
  parameter int MAX_FRAMES = 16,
  parameter int PAGE_BITS  = 16
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic [fpr_pkg::PAGE_IN_W-1:0]   page_number,
  output logic                            done,
  output logic                            hit,
  output logic [fpr_pkg::SLOT_W-1:0]      slot,
  output logic [fpr_pkg::TOTAL_W-1:0]     fault_total,
  output logic [fpr_pkg::TOTAL_W-1:0]     hit_total,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [fpr_pkg::CFG_AW-1:0]      paddr,
  input  logic [fpr_pkg::CFG_DW-1:0]      pwdata,
  output logic [fpr_pkg::CFG_DW-1:0]      prdata,
  output logic                            pready
);

  import fpr_pkg::*;

  logic [NF_W-1:0] num_frames;
  logic            cfg_wr;
  ctl_cmd_t        cmd;
  dp_stat_t        stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr == REG_NUM_FRAMES);

  always_ff @(posedge clk) begin
    if (rst) begin
      num_frames <= NUM_FRAMES_RESET;
    end else if (cfg_wr) begin
      num_frames <= pwdata[NF_W-1:0];
    end
  end

  assign prdata = (paddr == REG_NUM_FRAMES) ? CFG_DW'(num_frames) : '0;

  fpr_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  fpr_dp #(
    .MAX_FRAMES (MAX_FRAMES),
    .PAGE_BITS  (PAGE_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .stat        (stat),
    .page_number (page_number),
    .num_frames  (num_frames),
    .done        (done),
    .hit         (hit),
    .slot        (slot),
    .fault_total (fault_total),
    .hit_total   (hit_total)
  );

endmodule

FILE: bench/fifo_page_replacement_unit_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// fifo_page_replacement_unit_tb
// Self-checking bench for the fifo page replacement unit. A queue of page
// references feeds a burst/gap driver. The monitor keeps its own frame table,
// fill pointer and totals, and checks every result strobe field by field
// against the oldest predicted lookup. num_frames is changed between phases
// while the unit is idle.
// ----------------------------------------------------------------------------
module fifo_page_replacement_unit_tb;
  import fpr_pkg::*;

  localparam int                FRAMES_BUILT  = 16;
  localparam int                STALL_LIMIT   = 4000;
  localparam int                END_PAUSE     = 40;
  localparam logic [CFG_AW-1:0] UNMAPPED_ADDR = 2'd3;

  typedef struct packed {
    logic               hit;
    logic [SLOT_W-1:0]  slot;
    logic [TOTAL_W-1:0] faults;
    logic [TOTAL_W-1:0] hits;
  } page_result_t;

  logic                 clk;
  logic                 rst;
  logic                 start;
  logic                 busy;
  logic [PAGE_IN_W-1:0] page_number;
  logic                 done;
  logic                 hit;
  logic [SLOT_W-1:0]    slot;
  logic [TOTAL_W-1:0]   fault_total;
  logic [TOTAL_W-1:0]   hit_total;
  logic                 psel;
  logic                 penable;
  logic                 pwrite;
  logic [CFG_AW-1:0]    paddr;
  logic [CFG_DW-1:0]    pwdata;
  logic [CFG_DW-1:0]    prdata;
  logic                 pready;

  fifo_page_replacement_unit u_top (
    .clk         (clk),
    .rst         (rst),
    .start       (start),
    .busy        (busy),
    .page_number (page_number),
    .done        (done),
    .hit         (hit),
    .slot        (slot),
    .fault_total (fault_total),
    .hit_total   (hit_total),
    .psel        (psel),
    .penable     (penable),
    .pwrite      (pwrite),
    .paddr       (paddr),
    .pwdata      (pwdata),
    .prdata      (prdata),
    .pready      (pready)
  );

  // stimulus side
  logic [PAGE_IN_W-1:0] page_refs[$];
  int unsigned          issued_refs;
  int unsigned          accepted_refs;
  int unsigned          burst_left;
  int unsigned          idle_left;
  bit                   gaps_on;
  logic                 req_accepted;
  logic                 cfg_done;

  // shadow of the unit
  page_result_t         pending_lookups[$];
  logic [NF_W-1:0]      nf_cfg;
  logic [PAGE_IN_W-1:0] frame_pg[FRAMES_BUILT];
  logic                 frame_vld[FRAMES_BUILT];
  logic [SLOT_W-1:0]    fill_ptr;
  logic [TOTAL_W-1:0]   fault_cnt;
  logic [TOTAL_W-1:0]   hit_cnt;

  int unsigned          err_cnt;
  int unsigned          quiet_cycles;

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  function automatic void note_mismatch(string what, logic [31:0] want, logic [31:0] got);
    err_cnt++;
    if (err_cnt <= 10) begin
      $display("mismatch on %s: expected %0h, got %0h", what, want, got);
    end
  endfunction

  // lookup, then fifo fill on a miss
  function automatic page_result_t resolve_reference(input logic [PAGE_IN_W-1:0] pg);
    page_result_t r;
    int unsigned  in_use;
    int unsigned  victim;
    int unsigned  nxt;
    bit           found;
    if (nf_cfg == 0) in_use = 1;
    else if (nf_cfg > FRAMES_BUILT) in_use = FRAMES_BUILT;
    else in_use = 32'(nf_cfg);
    found  = 1'b0;
    r.slot = '0;
    for (int k = 0; k < in_use; k++) begin
      if (!found && frame_vld[k] && frame_pg[k] == pg) begin
        found  = 1'b1;
        r.slot = SLOT_W'(k);
      end
    end
    if (found) begin
      hit_cnt = hit_cnt + 1;
    end else begin
      // pointer left beyond a shrunk frame count restarts at frame 0
      victim = (fill_ptr >= in_use) ? 0 : 32'(fill_ptr);
      frame_pg[victim]  = pg;
      frame_vld[victim] = 1'b1;
      nxt = victim + 1;
      if (nxt >= in_use) nxt = 0;
      fill_ptr  = SLOT_W'(nxt);
      fault_cnt = fault_cnt + 1;
      r.slot    = SLOT_W'(victim);
    end
    r.hit    = found;
    r.faults = fault_cnt;
    r.hits   = hit_cnt;
    return r;
  endfunction

  // driver: bursts of requests, separated by random gaps while gaps_on is set
  always @(negedge clk) begin
    if (!rst && (!start || req_accepted)) begin
      if (idle_left != 0) begin
        start       <= 1'b0;
        page_number <= PAGE_IN_W'($urandom);
        idle_left   <= idle_left - 1;
      end else if (page_refs.size() != 0) begin
        start       <= 1'b1;
        page_number <= page_refs.pop_front();
        if (burst_left <= 1) begin
          burst_left <= $urandom_range(1, 12);
          idle_left  <= gaps_on ? $urandom_range(0, 20) : 0;
        end else begin
          burst_left <= burst_left - 1;
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor and predictor
  always @(posedge clk) begin : mon
    page_result_t want;
    if (rst) begin
      req_accepted <= 1'b0;
      cfg_done     <= 1'b0;
      nf_cfg    = NUM_FRAMES_RESET;
      fill_ptr  = '0;
      fault_cnt = '0;
      hit_cnt   = '0;
      for (int k = 0; k < FRAMES_BUILT; k++) frame_vld[k] = 1'b0;
    end else begin
      req_accepted <= start && !busy;
      cfg_done     <= psel && penable && pready;
      if (psel && penable && pready) begin
        if (pwrite && paddr == REG_NUM_FRAMES) begin
          nf_cfg = pwdata[NF_W-1:0];
        end else if (!pwrite && paddr == REG_NUM_FRAMES
                     && prdata !== CFG_DW'(nf_cfg)) begin
          note_mismatch("num_frames read", CFG_DW'(nf_cfg), prdata);
        end
      end
      if (done) begin
        if (pending_lookups.size() == 0) begin
          note_mismatch("result with no request pending", 0, 1);
        end else begin
          want = pending_lookups.pop_front();
          if (hit !== want.hit) note_mismatch("hit", 32'(want.hit), 32'(hit));
          if (slot !== want.slot) note_mismatch("slot", 32'(want.slot), 32'(slot));
          if (fault_total !== want.faults) note_mismatch("fault_total", want.faults, fault_total);
          if (hit_total !== want.hits) note_mismatch("hit_total", want.hits, hit_total);
        end
      end
      if (start && !busy) begin
        pending_lookups.push_back(resolve_reference(page_number));
        accepted_refs++;
      end
    end
  end

  // watchdog on cycles with no handshake at all
  always @(posedge clk) begin
    if (rst || (start && !busy) || done || (psel && penable && pready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == STALL_LIMIT) begin
      $display("status: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic cfg_access(input bit wr, input logic [CFG_AW-1:0] addr,
                            input logic [CFG_DW-1:0] data);
    @(negedge clk);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= wr;
    paddr   <= addr;
    pwdata  <= data;
    @(negedge clk);
    penable <= 1'b1;
    do @(negedge clk); while (!cfg_done);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic queue_ref(input logic [PAGE_IN_W-1:0] pg);
    page_refs.push_back(pg);
    issued_refs++;
  endtask

  task automatic drain_refs();
    while (accepted_refs != issued_refs || pending_lookups.size() != 0) @(negedge clk);
  endtask

  initial begin : stim
    logic [PAGE_IN_W-1:0] pool[$];
    logic [NF_W-1:0]      nf_pick;
    int unsigned          pool_size;
    rst           = 1'b1;
    start         = 1'b0;
    page_number   = '0;
    psel          = 1'b0;
    penable       = 1'b0;
    pwrite        = 1'b0;
    paddr         = '0;
    pwdata        = '0;
    issued_refs   = 0;
    accepted_refs = 0;
    burst_left    = 1;
    idle_left     = 0;
    gaps_on       = 1'b0;
    err_cnt       = 0;
    quiet_cycles  = 0;
    repeat (8) @(negedge clk);
    rst <= 1'b0;

    // directed: reset frame count, fill and wrap of the fifo pointer
    cfg_access(1'b0, REG_NUM_FRAMES, '0);
    queue_ref(16'h0000);
    queue_ref(16'hFFFF);
    queue_ref(16'h0000);
    queue_ref(16'hFFFF);
    queue_ref(16'h5555);
    queue_ref(16'hAAAA);
    queue_ref(16'h5555);
    queue_ref(16'h1234);
    queue_ref(16'h0000);
    drain_refs();

    // write to an unmapped address leaves num_frames alone
    cfg_access(1'b1, UNMAPPED_ADDR, 32'h0000_0001);
    cfg_access(1'b0, REG_NUM_FRAMES, '0);
    queue_ref(16'hAAAA);
    drain_refs();

    // shrink to one frame with the pointer beyond it, then grow back so that
    // two frames hold the same page and the lower one must win
    cfg_access(1'b1, REG_NUM_FRAMES, 32'd1);
    queue_ref(16'h5555);
    drain_refs();
    cfg_access(1'b1, REG_NUM_FRAMES, 32'd4);
    queue_ref(16'h5555);
    drain_refs();

    // zero frames acts as one
    cfg_access(1'b1, REG_NUM_FRAMES, 32'd0);
    queue_ref(16'h0001);
    queue_ref(16'h0001);
    queue_ref(16'h0002);
    drain_refs();

    // oversized count clamps to the built frame count
    cfg_access(1'b1, REG_NUM_FRAMES, 32'hFFFF_FFFF);
    cfg_access(1'b0, REG_NUM_FRAMES, '0);
    queue_ref(16'h8000);
    queue_ref(16'h7FFF);
    queue_ref(16'h0002);
    drain_refs();

    cfg_access(1'b1, REG_NUM_FRAMES, 32'd16);
    queue_ref(16'h8000);
    queue_ref(16'h00FF);
    drain_refs();

    // random phases: small working sets for hits, full-range pages as noise
    for (int ph = 0; ph < 12; ph++) begin
      case (ph)
        0:       nf_pick = 5'd16;
        1:       nf_pick = 5'd1;
        2:       nf_pick = 5'd31;
        3:       nf_pick = 5'd0;
        4:       nf_pick = 5'd17;
        default: nf_pick = NF_W'($urandom_range(1, 16));
      endcase
      if (ph != 7) begin
        cfg_access(1'b1, REG_NUM_FRAMES, ($urandom & ~32'h1F) | CFG_DW'(nf_pick));
      end
      if (ph % 3 == 1) begin
        cfg_access(1'b1, UNMAPPED_ADDR, $urandom);
        cfg_access(1'b0, REG_NUM_FRAMES, '0);
      end
      gaps_on   = (ph % 4 != 3);
      pool_size = $urandom_range(1, 20);
      pool.delete();
      for (int i = 0; i < pool_size; i++) pool.push_back(PAGE_IN_W'($urandom));
      for (int i = 0; i < 78; i++) begin
        if ($urandom_range(0, 9) < 8) queue_ref(pool[$urandom_range(0, pool_size - 1)]);
        else queue_ref(PAGE_IN_W'($urandom));
      end
      drain_refs();
    end

    repeat (END_PAUSE) @(posedge clk);
    if (pending_lookups.size() != 0) begin
      note_mismatch("results still outstanding", 0, 32'(pending_lookups.size()));
    end
    if (err_cnt == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

FILE: sim.f
rtl/fpr_pkg.sv
rtl/fpr_ram.sv
rtl/fpr_ctrl.sv
rtl/fpr_dp.sv
rtl/fifo_page_replacement_unit.sv
bench/fifo_page_replacement_unit_tb.sv
